// ----- hw/rtl/hlr_pkg.sv -----
// ----------------------------------------------------------------------------
// hlr_pkg: shared types and constants for the histogram rectangle block
// Sizes of the column stack, field widths, the sequencer states and the
// command and status groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package hlr_pkg;

    // capacity of the column stack
    localparam int MAX_COLUMNS = 1024;

    // field widths
    localparam int HEIGHT_W = 16;
    localparam int AREA_W   = 26;
    localparam int IDX_W    = $clog2(MAX_COLUMNS);
    localparam int CNT_W    = $clog2(MAX_COLUMNS + 1);
    localparam int PROD_W   = HEIGHT_W + CNT_W;

    // saturation limit of a score
    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    // one stack entry: first column of the run and its height
    typedef struct packed {
        logic [IDX_W-1:0]    start;
        logic [HEIGHT_W-1:0] height;
    } t_entry;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_LOAD,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic drop;
        logic pop;
        logic load_top;
        logic push;
        logic flush_start;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_full;
        logic can_pop;
        logic flushing;
        logic last;
        logic out_free;
    } t_status;

endpackage

// ----- hw/rtl/hlr_col_if.sv -----
// ----------------------------------------------------------------------------
// hlr_col_if: column channel
// Valid/ready channel carrying one histogram column per item.
// ----------------------------------------------------------------------------
interface hlr_col_if import hlr_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] column_height;
    logic                last_column;

    modport source (output valid, output column_height, output last_column, input ready);
    modport sink   (input valid, input column_height, input last_column, output ready);

endinterface

// ----- hw/rtl/hlr_res_if.sv -----
// ----------------------------------------------------------------------------
// hlr_res_if: result channel
// Valid/ready channel carrying the largest area of one histogram per item.
// ----------------------------------------------------------------------------
interface hlr_res_if import hlr_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [AREA_W-1:0] max_area;
    logic              overflow;

    modport source (output valid, output max_area, output overflow, input ready);
    modport sink   (input valid, input max_area, input overflow, output ready);

endinterface

// ----- hw/rtl/hlr_datapath.sv -----
// ----------------------------------------------------------------------------
// hlr_datapath: column stack, scoring and result register
// Holds the top of the monotonic stack in a register and the rest in a memory with
// one write and one registered read port; scores each pop and keeps the best.
// ----------------------------------------------------------------------------
module hlr_datapath import hlr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [HEIGHT_W-1:0] i_column_height,
    input  logic                i_last_column,
    input  logic                i_out_ready,
    output t_status             o_status,
    output logic                o_out_valid,
    output logic [AREA_W-1:0]   o_max_area,
    output logic                o_overflow
);

    // stack storage below the top entry
    t_entry              r_stack [MAX_COLUMNS];
    t_entry              r_rdata;
    t_entry              r_top;

    // control state
    logic [CNT_W-1:0]    r_depth;
    logic [CNT_W-1:0]    r_count;
    logic [AREA_W-1:0]   r_best;
    logic                r_ovf;
    logic                r_flush;
    logic                r_out_valid;

    // working payload
    logic [HEIGHT_W-1:0] r_h;
    logic                r_last;
    logic [CNT_W-1:0]    r_pos;
    logic [IDX_W-1:0]    r_start;
    logic [PROD_W-1:0]   r_prod;
    logic [AREA_W-1:0]   r_out_area;
    logic                r_out_ovf;

    logic [CNT_W-1:0]    w_dm1;
    logic [CNT_W-1:0]    w_dm2;
    logic [CNT_W-1:0]    w_span;
    logic [AREA_W-1:0]   w_score;
    logic                w_depth_zero;

    // address the top is written to on push, and address of the entry just below the top
    assign w_dm1        = r_depth - CNT_W'(1);
    assign w_dm2        = r_depth - CNT_W'(2);
    assign w_depth_zero = (r_depth == '0);
    assign w_span       = r_pos - CNT_W'(r_top.start);
    assign w_score      = (r_prod > PROD_W'(AREA_MAX)) ? AREA_MAX : r_prod[AREA_W-1:0];

    // status towards the controller
    assign o_status.count_full = (r_count >= CNT_W'(MAX_COLUMNS));
    assign o_status.can_pop    = !w_depth_zero && (r_top.height >= r_h);
    assign o_status.flushing   = r_flush;
    assign o_status.last       = r_last;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // stack memory: write on push, read every cycle at the next-to-top slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !w_depth_zero) begin
            r_stack[w_dm1[IDX_W-1:0]] <= r_top;
        end
        r_rdata <= r_stack[w_dm2[IDX_W-1:0]];
    end

    // working payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_h     <= i_column_height;
            r_last  <= i_last_column;
            r_pos   <= r_count;
            r_start <= r_count[IDX_W-1:0];
        end
        if (i_cmd.pop) begin
            r_prod  <= PROD_W'(r_top.height) * PROD_W'(w_span);
            r_start <= r_top.start;
        end
        if (i_cmd.load_top) begin
            r_top <= r_rdata;
        end
        if (i_cmd.push) begin
            r_top <= '{start: r_start, height: r_h};
        end
        // flush pops everything against a zero-height sentinel
        if (i_cmd.flush_start) begin
            r_h    <= '0;
            r_last <= 1'b0;
            r_pos  <= i_cmd.push ? (r_count + CNT_W'(1)) : r_count;
        end
        if (i_cmd.emit) begin
            r_out_area <= r_best;
            r_out_ovf  <= r_ovf;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_count     <= '0;
            r_best      <= '0;
            r_ovf       <= 1'b0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_flush <= 1'b0;
            end
            if (i_cmd.flush_start) begin
                r_flush <= 1'b1;
            end
            if (i_cmd.pop) begin
                r_depth <= w_dm1;
            end
            if (i_cmd.push) begin
                r_depth <= r_depth + CNT_W'(1);
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.drop) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.load_top && (w_score > r_best)) begin
                r_best <= w_score;
            end
            // hand over the result and return to the empty histogram
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_depth     <= '0;
                r_count     <= '0;
                r_best      <= '0;
                r_ovf       <= 1'b0;
                r_flush     <= 1'b0;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_max_area  = r_out_area;
    assign o_overflow  = r_out_ovf;

endmodule

// ----- hw/rtl/hlr_ctrl.sv -----
// ----------------------------------------------------------------------------
// hlr_ctrl: sequencer for the column stack
// Takes a column, pops entries not below it (reloading the top after each), pushes it,
// and on the last column flushes the stack and hands over the result.
// ----------------------------------------------------------------------------
module hlr_ctrl import hlr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.count_full && !i_in_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                priority if (i_status.can_pop) begin
                    n_state = ST_LOAD;
                end else if (i_status.flushing) begin
                    n_state = ST_EMIT;
                end else if (i_status.last) begin
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOAD: begin
                n_state = ST_CMP;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    // drop a column beyond capacity, still honour its last mark
                    if (i_status.count_full) begin
                        o_cmd.drop        = 1'b1;
                        o_cmd.flush_start = i_in_last;
                    end else begin
                        o_cmd.capture = 1'b1;
                    end
                end
            end
            ST_CMP: begin
                priority if (i_status.can_pop) begin
                    o_cmd.pop = 1'b1;
                end else if (!i_status.flushing) begin
                    o_cmd.push        = 1'b1;
                    o_cmd.flush_start = i_status.last;
                end
            end
            ST_LOAD: begin
                o_cmd.load_top = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/histogram_largest_rectangle.sv -----
// ----------------------------------------------------------------------------
// histogram_largest_rectangle: largest rectangle under a streamed histogram
//
//   channel  dir  payload                      item
//   i_col    in   column_height[15:0], last    one histogram column
//   o_res    out  max_area[25:0], overflow     one result per histogram
//
// A column is accepted, scores and pops each stack entry not below it, and is
// then pushed; each pop waits for the registered read of the stack memory.
// The last column then flushes every entry left on the stack and the result
// is emitted; a column dropped beyond capacity is discarded at acceptance.
// Reset is synchronous and needs no clearing pass: the stack is empty.
// A pending result waits in the output register; a further histogram stalls
// only at its own emit step until that register is free.
// ----------------------------------------------------------------------------
module histogram_largest_rectangle import hlr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hlr_col_if.sink   i_col,
    hlr_res_if.source o_res
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer
    hlr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_col.valid),
        .i_in_last  (i_col.last_column),
        .i_status   (w_status),
        .o_in_ready (i_col.ready),
        .o_cmd      (w_cmd)
    );

    // stack, scoring and result register
    hlr_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_column_height (i_col.column_height),
        .i_last_column   (i_col.last_column),
        .i_out_ready     (o_res.ready),
        .o_status        (w_status),
        .o_out_valid     (o_res.valid),
        .o_max_area      (o_res.max_area),
        .o_overflow      (o_res.overflow)
    );

`ifndef SYNTHESIS
    // a pop and a push never share a cycle
    a_pop_push_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.pop && w_cmd.push))
        else $error("pop and push in the same cycle");

    // every pop is followed by loading the new top
    a_pop_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |=> w_cmd.load_top)
        else $error("pop not followed by top reload");

    // a result is only loaded when the output register is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_status.out_free)
        else $error("result overwrites a pending item");

    // a new result appears only after an emit
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(w_cmd.emit))
        else $error("result valid without emit");
`endif

endmodule
